// ===== rtl/void_cluster_influence_grid_assert.svh =====
// Assertion macros shared by the checker.
// No dependencies.
`ifndef VOID_CLUSTER_INFLUENCE_GRID_ASSERT_SVH
`define VOID_CLUSTER_INFLUENCE_GRID_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define VCIG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define VCIG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/vcig_pkg.sv =====
// Package for the influence-grid engine: grid size, commands, kernel table, controller states, control structs.
// No dependencies.
package vcig_pkg;
	localparam int GRID_W = 64;         // columns of the half tile
	localparam int GRID_H = GRID_W / 2; // rows of the half tile

	localparam logic [1:0] CMD_SET = 2'd0;
	localparam logic [1:0] CMD_CLR = 2'd1;
	localparam logic [1:0] CMD_ALL = 2'd2;
	localparam int KROM_LEN = 34;

	typedef enum logic [6:0] {
		ST_INIT  = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_WIPE  = 7'b0000100,
		ST_KRD   = 7'b0001000,
		ST_KWR   = 7'b0010000,
		ST_SCAN  = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic load;     // latch command and pixel
		logic wipe;     // clear-all sweep step
		logic krd;      // issue kernel-window read
		logic kwr;      // write updated kernel cell
		logic scan_rd;  // issue scan read
		logic scan_st;  // start scan
		logic fin;      // finish: latch result
	} ctl_t;

	typedef struct packed {
		logic wipe_last;
		logic win_last;
		logic scan_last;
		logic scan_drain;
	} sts_t;

	function automatic logic [31:0] krom(input logic [5:0] r2);
		logic [31:0] t;
		case (r2)
			6'd0: t = 65536; 6'd1: t = 46311; 6'd2: t = 32726; 6'd3: t = 23125;
			6'd4: t = 16342; 6'd5: t = 11548; 6'd6: t = 8160; 6'd7: t = 5766;
			6'd8: t = 4075; 6'd9: t = 2879; 6'd10: t = 2035; 6'd11: t = 1438;
			6'd12: t = 1016; 6'd13: t = 718; 6'd14: t = 507; 6'd15: t = 359;
			6'd16: t = 253; 6'd17: t = 179; 6'd18: t = 127; 6'd19: t = 89;
			6'd20: t = 63; 6'd21: t = 45; 6'd22: t = 32; 6'd23: t = 22;
			6'd24: t = 16; 6'd25: t = 11; 6'd26: t = 8; 6'd27: t = 6;
			6'd28: t = 4; 6'd29: t = 3; 6'd30: t = 2; 6'd31: t = 1;
			6'd32: t = 1; 6'd33: t = 1;
			default: t = 0;
		endcase
		return t;
	endfunction
endpackage

// ===== rtl/void_cluster_influence_grid.sv =====
// Void-and-cluster influence grid: a set or clear walks the 31x31 window, reading and
// writing back each cell, then scans all 2048 cells at one a cycle and drains the last read.
// Clear all wipes store and pattern and then scans; other codes scan only. One item at a
// time; the next may transfer in the done cycle. Reset clears the found flags and runs a
// clearing pass of the store and pattern with busy high; done strobes one cycle and the
// receiver cannot stall it.
module void_cluster_influence_grid import vcig_pkg::*; #(
	parameter int KERNEL_FRACTION_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] command,
	input  logic [5:0] pixel_x,
	input  logic [4:0] pixel_y,
	output logic       done,
	output logic [5:0] void_x,
	output logic [4:0] void_y,
	output logic [5:0] cluster_x,
	output logic [4:0] cluster_y,
	output logic       void_found,
	output logic       cluster_found
);
	ctl_t ctl;
	sts_t sts;

	// sequence each transfer through wipe, window update and scan
	vcig_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .command(command),
		.sts(sts), .ctl(ctl), .busy(busy), .done(done)
	);

	// hold store, pattern and running min/max
	vcig_dp #(.KERNEL_FRACTION_BITS(KERNEL_FRACTION_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.command(command), .pixel_x(pixel_x), .pixel_y(pixel_y),
		.void_x(void_x), .void_y(void_y), .cluster_x(cluster_x), .cluster_y(cluster_y),
		.void_found(void_found), .cluster_found(cluster_found)
	);
endmodule

// ===== rtl/vcig_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module vcig_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/vcig_ctrl.sv =====
// Controller state machine of the influence-grid engine.
// Depends on vcig_pkg.
module vcig_ctrl import vcig_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] command,
	input  sts_t       sts,
	output ctl_t       ctl,
	output logic       busy,
	output logic       done
);
	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		ctl = '0;
		unique case (state_q)
			ST_INIT: begin
				ctl.wipe = 1'b1;
				if (sts.wipe_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					if (command == CMD_ALL) state_d = ST_WIPE;
					else if (command == CMD_SET || command == CMD_CLR) state_d = ST_KRD;
					else begin
						state_d = ST_SCAN;
						ctl.scan_st = 1'b1;
					end
				end
			end
			ST_WIPE: begin
				ctl.wipe = 1'b1;
				if (sts.wipe_last) begin
					state_d = ST_SCAN;
					ctl.scan_st = 1'b1;
				end
			end
			ST_KRD: begin
				ctl.krd = 1'b1;
				state_d = ST_KWR;
			end
			ST_KWR: begin
				ctl.kwr = 1'b1;
				if (sts.win_last) begin
					state_d = ST_SCAN;
					ctl.scan_st = 1'b1;
				end else state_d = ST_KRD;
			end
			ST_SCAN: begin
				ctl.scan_rd = 1'b1;
				if (sts.scan_drain) state_d = ST_DONE;
			end
			ST_DONE: begin
				ctl.fin = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_INIT;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= ctl.fin;
	end

	assign busy = (state_q != ST_IDLE);
endmodule

// ===== rtl/vcig_dp.sv =====
// Datapath: influence RAM, pattern RAM, window walker, scan comparators.
// Depends on vcig_pkg and vcig_ram.
module vcig_dp import vcig_pkg::*; #(
	parameter int KERNEL_FRACTION_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctl_t       ctl,
	output sts_t       sts,
	input  logic [1:0] command,
	input  logic [5:0] pixel_x,
	input  logic [4:0] pixel_y,
	output logic [5:0] void_x,
	output logic [4:0] void_y,
	output logic [5:0] cluster_x,
	output logic [4:0] cluster_y,
	output logic       void_found,
	output logic       cluster_found
);
	localparam int W = GRID_W;
	localparam int H = GRID_H;
	localparam int R = H / 2 - 1;
	localparam int CELLS = W * H;
	localparam int XB = $clog2(W);
	localparam int YB = $clog2(H);
	localparam int AB = XB + YB;
	localparam int DB = $clog2(2 * R + 2) + 1; // signed offset width
	localparam int CB = XB + 3;                 // signed coordinate width

	logic          add_q;
	logic [XB-1:0] px_q;
	logic [YB-1:0] py_q;
	logic signed [DB-1:0] dx_q, dy_q;
	logic [AB-1:0] wipe_q, scan_q;
	logic          scan_v_s1;
	logic [AB-1:0] scan_a_s1;
	logic          scan_issued_last_q;
	logic [AB-1:0] kaddr_q;
	logic [31:0]   kw_q;

	logic          we;
	logic [AB-1:0] waddr, raddr;
	logic [31:0]   wdata, rdata;

	logic          pwe;
	logic [AB-1:0] pwaddr;
	logic          pwdata, pbit;

	vcig_ram #(.WIDTH(32), .DEPTH(CELLS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// pattern bits, read in step with the influence RAM during the scan
	vcig_ram #(.WIDTH(1), .DEPTH(CELLS)) u_pat (
		.clk(clk), .we(pwe), .waddr(pwaddr), .wdata(pwdata), .raddr(scan_q), .rdata(pbit)
	);

	// window cell address with horizontal wrap and point flip
	logic signed [CB-1:0] cx, cy, fx, fy;
	logic [XB-1:0] wx;
	logic [YB-1:0] wy;
	logic [AB-1:0] caddr;
	logic [12:0]   r2;
	logic [31:0]   kw;
	always_comb begin
		cx = CB'($signed({1'b0, px_q})) + CB'(dx_q);
		cy = CB'($signed({1'b0, py_q})) + CB'(dy_q);
		if (cy >= 0 && cy < CB'(H)) begin
			fx = cx;
			fy = cy;
		end else begin
			fx = CB'(2 * W - 1) - cx;
			fy = CB'(2 * H - 1) - cy;
		end
		if (fx >= CB'(W)) fx = fx - CB'(W);
		else if (fx < 0) fx = fx + CB'(W);
		if (fy >= CB'(H)) fy = fy - CB'(H);
		else if (fy < 0) fy = fy + CB'(H);
		wx = fx[XB-1:0];
		wy = fy[YB-1:0];
		caddr = {wy, wx};
		r2 = 13'(dx_q * dx_q) + 13'(dy_q * dy_q);
		if (r2 >= 13'(KROM_LEN)) kw = '0;
		else if (KERNEL_FRACTION_BITS >= 16)
			kw = krom(r2[5:0]) << (KERNEL_FRACTION_BITS - 16);
		else
			kw = (krom(r2[5:0]) + ((32'd1 << (16 - KERNEL_FRACTION_BITS)) >> 1))
				>> (16 - KERNEL_FRACTION_BITS);
	end

	assign sts.wipe_last  = (wipe_q == AB'(CELLS - 1));
	assign sts.win_last   = (dx_q == DB'(R)) && (dy_q == DB'(R));
	assign sts.scan_last  = (scan_q == AB'(CELLS - 1));
	assign sts.scan_drain = scan_v_s1 && (scan_a_s1 == AB'(CELLS - 1));

	assign raddr = ctl.krd ? caddr : scan_q;
	assign we    = ctl.wipe | ctl.kwr;
	assign waddr = ctl.wipe ? wipe_q : kaddr_q;
	assign wdata = ctl.wipe ? 32'd0 : (add_q ? rdata + kw_q : rdata - kw_q);

	assign pwe    = ctl.wipe | (ctl.load && (command == CMD_SET || command == CMD_CLR));
	assign pwaddr = ctl.wipe ? wipe_q : {YB'(pixel_y % H), XB'(pixel_x % W)};
	assign pwdata = !ctl.wipe && (command == CMD_SET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_q <= '0;
			dx_q <= '0;
			dy_q <= '0;
			scan_q <= '0;
			scan_v_s1 <= 1'b0;
		end else begin
			if (ctl.load) begin
				wipe_q <= '0;
				dx_q <= -DB'(R);
				dy_q <= -DB'(R);
			end
			if (ctl.wipe) wipe_q <= wipe_q + 1'b1;
			if (ctl.kwr) begin
				if (dx_q == DB'(R)) begin
					dx_q <= -DB'(R);
					dy_q <= dy_q + 1'b1;
				end else dx_q <= dx_q + 1'b1;
			end
			if (ctl.scan_st) scan_q <= '0;
			else if (ctl.scan_rd && !sts.scan_last) scan_q <= scan_q + 1'b1;
			scan_v_s1 <= ctl.scan_rd && !scan_issued_last_q;
		end
	end

	// hold off issuing further reads once the final address went out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) scan_issued_last_q <= 1'b0;
		else if (ctl.scan_st) scan_issued_last_q <= 1'b0;
		else if (ctl.scan_rd && sts.scan_last) scan_issued_last_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			add_q <= (command == CMD_SET);
			px_q <= XB'(pixel_x % W);
			py_q <= YB'(pixel_y % H);
		end
		if (ctl.krd) begin
			kaddr_q <= caddr;
			kw_q <= kw;
		end
		scan_a_s1 <= scan_q;
	end

	// scan comparators: first min among zeros, first max among ones
	logic signed [31:0] vbest_q, cbest_q;
	logic vf_q, cf_q;
	logic [AB-1:0] vidx_q, cidx_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vf_q <= 1'b0; cf_q <= 1'b0;
			vidx_q <= '0; cidx_q <= '0;
			vbest_q <= '0; cbest_q <= '0;
			void_found <= 1'b0; cluster_found <= 1'b0;
		end else begin
			if (ctl.scan_st) begin
				vf_q <= 1'b0;
				cf_q <= 1'b0;
			end else if (scan_v_s1) begin
				if (!pbit) begin
					if (!vf_q || $signed(rdata) < vbest_q) begin
						vf_q <= 1'b1; vbest_q <= $signed(rdata); vidx_q <= scan_a_s1;
					end
				end else if (!cf_q || $signed(rdata) > cbest_q) begin
					cf_q <= 1'b1; cbest_q <= $signed(rdata); cidx_q <= scan_a_s1;
				end
			end
			if (ctl.fin) begin
				void_found <= vf_q;
				cluster_found <= cf_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			void_x <= 6'(vidx_q[XB-1:0]);
			void_y <= 5'(vidx_q[AB-1:XB]);
			cluster_x <= 6'(cidx_q[XB-1:0]);
			cluster_y <= 5'(cidx_q[AB-1:XB]);
		end
	end
endmodule

// ===== rtl/vcig_checker.sv =====
// Port-level checker for the influence-grid engine, bound to the top level.
// Depends on void_cluster_influence_grid_assert.svh.
`include "void_cluster_influence_grid_assert.svh"
module vcig_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	`VCIG_ASSERT_NEXT(a_start_busy, start && !busy, busy)
	`VCIG_ASSERT_NEXT(a_done_single, done, !done)
	`VCIG_ASSERT_IMP(a_done_after_busy, done, $past(busy))
endmodule

bind void_cluster_influence_grid vcig_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done)
);
